@@ design/pic_pkg.sv @@
package pic_pkg;

    localparam int COORD_BITS = 32;
    localparam int AXIS_BITS  = 16;
    localparam int FRAC_BITS  = 16;
    localparam int AXIS_FRAC  = AXIS_BITS - 2;

    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = DW + AXIS_BITS;
    localparam int DOTW  = PW + 2;
    localparam int LENW  = COORD_BITS - 1;
    localparam int RSW   = LENW + AXIS_FRAC;
    localparam int OFFW  = AXIS_BITS + COORD_BITS - 1;
    localparam int EW    = COORD_BITS + AXIS_BITS;
    localparam int SQW   = 2 * DW;
    localparam int RRW   = 2 * LENW;
    localparam int RL    = (RSW + 1) / 2;
    localparam int RH    = RSW - RL;
    localparam int EL    = (EW + 1) / 2;
    localparam int EH    = EW - EL;
    localparam int AXW   = 3 * AXIS_BITS;
    localparam int CFG_W = (COORD_BITS > AXW) ? COORD_BITS : AXW;
    localparam int IDX_W = 3;
    localparam int NSTAGE = 6;

    localparam logic [IDX_W-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_Y    = 3'd1;
    localparam logic [IDX_W-1:0] REG_CENTER_Z    = 3'd2;
    localparam logic [IDX_W-1:0] REG_AXIS_SIDE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_AXIS_LONG   = 3'd4;
    localparam logic [IDX_W-1:0] REG_AXIS_DEPTH  = 3'd5;
    localparam logic [IDX_W-1:0] REG_RADIUS      = 3'd6;
    localparam logic [IDX_W-1:0] REG_HALF_LENGTH = 3'd7;

    localparam logic [AXW-1:0] AXIS_ONE = AXW'(1) << AXIS_FRAC;
    localparam logic [LENW-1:0] RADIUS_RESET = LENW'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [COORD_BITS-1:0] center_z;
        logic [AXW-1:0]               axis_side;
        logic [AXW-1:0]               axis_long;
        logic [AXW-1:0]               axis_depth;
        logic [LENW-1:0]              radius;
        logic [LENW-1:0]              half_length;
        logic [RRW-1:0]               rad_sq;
    } cfg_t;

    typedef struct packed {
        logic radial_ok;
        logic body_in;
        logic sphere_in;
    } flags_t;

    function automatic logic signed [AXIS_BITS-1:0] axis_comp(
        input logic [AXW-1:0] v,
        input int             k
    );
        return $signed(v[k*AXIS_BITS +: AXIS_BITS]);
    endfunction

endpackage

@@ design/point_in_capsule_test_top.sv @@
// Point-in-capsule test.
// Configuration: write center_x/y/z, axis_side, axis_long, axis_depth, radius and
// half_length through cfg_valid/cfg_ready with cfg_index 0..7; cfg_ready is always
// high. Write only while no item is in flight.
// Input channel: point_x/y/z, taken at an edge with in_valid high and in_stall low.
// Output channel: inside_res, taken at an edge with out_valid high and out_stall low.
// Pipeline: six register stages (offset, axis projections, magnitudes, partial products,
// squares, final compare); out_valid rises when an item reaches the final compare.
// Throughput: one item per cycle while in_stall is low; the stages advance
// independently, so empty stages fill while the output is stalled.
// Stall: the output item holds while out_stall is high; in_stall rises only when
// every stage holds an item.
// Reset: rst_n low empties the pipeline and loads the default capsule, a unit
// sphere at the origin with identity axes.
module point_in_capsule_test_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pic_pkg::IDX_W-1:0]             cfg_index,
    input  logic [pic_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [pic_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [pic_pkg::COORD_BITS-1:0] point_y,
    input  logic signed [pic_pkg::COORD_BITS-1:0] point_z,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  inside_res
);
    import pic_pkg::*;

    cfg_t              cfg;
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;

    pic_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // advance a stage when it is empty or the next one advances
    always_comb
    begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || !out_stall;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < NSTAGE; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    pic_core u_core (
        .clk        (clk),
        .cfg        (cfg),
        .en         (en),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .inside_res (inside_res)
    );

    assign in_stall  = !en[0];
    assign out_valid = valid_reg[NSTAGE-1];

endmodule

@@ design/pic_regs.sv @@
module pic_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pic_pkg::IDX_W-1:0]   cfg_index,
    input  logic [pic_pkg::CFG_W-1:0]   cfg_data,
    output pic_pkg::cfg_t               cfg
);
    import pic_pkg::*;

    logic signed [COORD_BITS-1:0] center_x_reg;
    logic signed [COORD_BITS-1:0] center_y_reg;
    logic signed [COORD_BITS-1:0] center_z_reg;
    logic [AXW-1:0]               axis_side_reg;
    logic [AXW-1:0]               axis_long_reg;
    logic [AXW-1:0]               axis_depth_reg;
    logic [LENW-1:0]              radius_reg;
    logic [LENW-1:0]              half_length_reg;
    logic [RRW-1:0]               rad_sq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            center_z_reg    <= '0;
            axis_side_reg   <= AXIS_ONE;
            axis_long_reg   <= AXIS_ONE << AXIS_BITS;
            axis_depth_reg  <= AXIS_ONE << (2 * AXIS_BITS);
            radius_reg      <= RADIUS_RESET;
            half_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CENTER_X:    center_x_reg    <= $signed(cfg_data[COORD_BITS-1:0]);
                REG_CENTER_Y:    center_y_reg    <= $signed(cfg_data[COORD_BITS-1:0]);
                REG_CENTER_Z:    center_z_reg    <= $signed(cfg_data[COORD_BITS-1:0]);
                REG_AXIS_SIDE:   axis_side_reg   <= cfg_data[AXW-1:0];
                REG_AXIS_LONG:   axis_long_reg   <= cfg_data[AXW-1:0];
                REG_AXIS_DEPTH:  axis_depth_reg  <= cfg_data[AXW-1:0];
                REG_RADIUS:      radius_reg      <= cfg_data[LENW-1:0];
                REG_HALF_LENGTH: half_length_reg <= cfg_data[LENW-1:0];
                default:         ;
            endcase
        end
    end

    // radius squared is registered from the radius, so it follows a radius write in the next cycle
    always_ff @(posedge clk)
    begin
        rad_sq_reg <= RRW'(radius_reg) * RRW'(radius_reg);
    end

    always_comb
    begin
        cfg.center_x    = center_x_reg;
        cfg.center_y    = center_y_reg;
        cfg.center_z    = center_z_reg;
        cfg.axis_side   = axis_side_reg;
        cfg.axis_long   = axis_long_reg;
        cfg.axis_depth  = axis_depth_reg;
        cfg.radius      = radius_reg;
        cfg.half_length = half_length_reg;
        cfg.rad_sq      = rad_sq_reg;
    end

endmodule

@@ design/pic_core.sv @@
module pic_core (
    input  logic                                clk,
    input  pic_pkg::cfg_t                       cfg,
    input  logic [pic_pkg::NSTAGE-1:0]          en,
    input  logic signed [pic_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [pic_pkg::COORD_BITS-1:0] point_y,
    input  logic signed [pic_pkg::COORD_BITS-1:0] point_z,
    output logic                                inside_res
);
    import pic_pkg::*;

    logic signed [COORD_BITS-1:0] p [3];
    logic signed [COORD_BITS-1:0] c [3];
    logic [AXW-1:0]               ax [3];

    // stage 1
    logic signed [DW-1:0]   d_next [3];
    logic signed [DW-1:0]   d_reg [3];

    // stage 2
    logic signed [PW-1:0]   prod [3][3];
    logic signed [SQW-1:0]  sq_s [3];
    logic signed [DOTW-1:0] dot_next [3];
    logic [SQW-1:0]         sq_next [3];
    logic signed [OFFW-1:0] off_next [3];
    logic signed [DOTW-1:0] dot_reg [3];
    logic [SQW-1:0]         sq_reg [3];
    logic signed [OFFW-1:0] off_reg [3];
    logic signed [DW-1:0]   d2_reg [3];

    // stage 3
    logic [DOTW-1:0]        apx;
    logic [DOTW-1:0]        apy;
    logic [DOTW-1:0]        apz;
    logic [RSW-1:0]         rs;
    logic [RSW-1:0]         hs;
    logic                   pos;
    logic signed [EW-1:0]   dsh [3];
    logic signed [EW-1:0]   e [3];
    logic [EW-1:0]          ae_next [3];
    logic [SQW+1:0]         ssum;
    flags_t                 fl3_next;
    logic [RSW-1:0]         r_next [2];
    logic [RSW-1:0]         r_reg [2];
    logic [EW-1:0]          ae_reg [3];
    flags_t                 fl3_reg;

    // stage 4
    logic [2*RH-1:0]        r_hh_reg [2];
    logic [RH+RL-1:0]       r_hl_reg [2];
    logic [2*RL-1:0]        r_ll_reg [2];
    logic [2*EH-1:0]        e_hh_reg [3];
    logic [EH+EL-1:0]       e_hl_reg [3];
    logic [2*EL-1:0]        e_ll_reg [3];
    flags_t                 fl4_reg;

    // stage 5
    logic [2*RSW-1:0]       rsq_next [2];
    logic [2*EW-1:0]        esq_next [3];
    logic [2*RSW-1:0]       rsq_reg [2];
    logic [2*EW-1:0]        esq_reg [3];
    flags_t                 fl5_reg;

    // stage 6
    logic [2*RSW-1:0]       rs2;
    logic [2*RSW:0]         rsum;
    logic [2*EW+1:0]        esum;
    logic                   inside_next;
    logic                   inside_reg;

    always_comb
    begin
        p[0]  = point_x;
        p[1]  = point_y;
        p[2]  = point_z;
        c[0]  = cfg.center_x;
        c[1]  = cfg.center_y;
        c[2]  = cfg.center_z;
        ax[0] = cfg.axis_side;
        ax[1] = cfg.axis_long;
        ax[2] = cfg.axis_depth;
        for (int k = 0; k < 3; k++)
        begin
            d_next[k] = DW'(p[k]) - DW'(c[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                d_reg[k] <= d_next[k];
            end
        end
    end

    // project the offset on each axis, square it, and scale the long axis
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod[j][k] = d_reg[k] * axis_comp(ax[j], k);
            end
            dot_next[j] = DOTW'(prod[j][0]) + DOTW'(prod[j][1]) + DOTW'(prod[j][2]);
        end
        for (int k = 0; k < 3; k++)
        begin
            sq_s[k]     = d_reg[k] * d_reg[k];
            sq_next[k]  = $unsigned(sq_s[k]);
            off_next[k] = axis_comp(cfg.axis_long, k) * $signed({1'b0, cfg.half_length});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                dot_reg[k] <= dot_next[k];
                sq_reg[k]  <= sq_next[k];
                off_reg[k] <= off_next[k];
                d2_reg[k]  <= d_reg[k];
            end
        end
    end

    always_comb
    begin
        apx = dot_reg[0][DOTW-1] ? $unsigned(-dot_reg[0]) : $unsigned(dot_reg[0]);
        apy = dot_reg[1][DOTW-1] ? $unsigned(-dot_reg[1]) : $unsigned(dot_reg[1]);
        apz = dot_reg[2][DOTW-1] ? $unsigned(-dot_reg[2]) : $unsigned(dot_reg[2]);
        rs  = {cfg.radius, {AXIS_FRAC{1'b0}}};
        hs  = {cfg.half_length, {AXIS_FRAC{1'b0}}};
        pos = !dot_reg[1][DOTW-1];
        for (int k = 0; k < 3; k++)
        begin
            dsh[k]     = EW'($signed({d2_reg[k], {AXIS_FRAC{1'b0}}}));
            e[k]       = pos ? (dsh[k] - EW'(off_reg[k])) : (dsh[k] + EW'(off_reg[k]));
            ae_next[k] = e[k][EW-1] ? $unsigned(-e[k]) : $unsigned(e[k]);
        end
        ssum = (SQW+2)'(sq_reg[0]) + (SQW+2)'(sq_reg[1]) + (SQW+2)'(sq_reg[2]);
        fl3_next.radial_ok = (apx <= DOTW'(rs)) && (apz <= DOTW'(rs));
        fl3_next.body_in   = apy < DOTW'(hs);
        fl3_next.sphere_in = ssum <= (SQW+2)'(cfg.rad_sq);
        r_next[0] = apx[RSW-1:0];
        r_next[1] = apz[RSW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            r_reg[0] <= r_next[0];
            r_reg[1] <= r_next[1];
            for (int k = 0; k < 3; k++)
            begin
                ae_reg[k] <= ae_next[k];
            end
            fl3_reg <= fl3_next;
        end
    end

    // split each square into partial products
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int k = 0; k < 2; k++)
            begin
                r_hh_reg[k] <= (2*RH)'(r_reg[k][RSW-1:RL]) * (2*RH)'(r_reg[k][RSW-1:RL]);
                r_hl_reg[k] <= (RH+RL)'(r_reg[k][RSW-1:RL]) * (RH+RL)'(r_reg[k][RL-1:0]);
                r_ll_reg[k] <= (2*RL)'(r_reg[k][RL-1:0]) * (2*RL)'(r_reg[k][RL-1:0]);
            end
            for (int k = 0; k < 3; k++)
            begin
                e_hh_reg[k] <= (2*EH)'(ae_reg[k][EW-1:EL]) * (2*EH)'(ae_reg[k][EW-1:EL]);
                e_hl_reg[k] <= (EH+EL)'(ae_reg[k][EW-1:EL]) * (EH+EL)'(ae_reg[k][EL-1:0]);
                e_ll_reg[k] <= (2*EL)'(ae_reg[k][EL-1:0]) * (2*EL)'(ae_reg[k][EL-1:0]);
            end
            fl4_reg <= fl3_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            rsq_next[k] = ((2*RSW)'(r_hh_reg[k]) << (2*RL))
                        + ((2*RSW)'(r_hl_reg[k]) << (RL+1))
                        + (2*RSW)'(r_ll_reg[k]);
        end
        for (int k = 0; k < 3; k++)
        begin
            esq_next[k] = ((2*EW)'(e_hh_reg[k]) << (2*EL))
                        + ((2*EW)'(e_hl_reg[k]) << (EL+1))
                        + (2*EW)'(e_ll_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            rsq_reg[0] <= rsq_next[0];
            rsq_reg[1] <= rsq_next[1];
            for (int k = 0; k < 3; k++)
            begin
                esq_reg[k] <= esq_next[k];
            end
            fl5_reg <= fl4_reg;
        end
    end

    always_comb
    begin
        rs2  = {cfg.rad_sq, {(2*AXIS_FRAC){1'b0}}};
        rsum = (2*RSW+1)'(rsq_reg[0]) + (2*RSW+1)'(rsq_reg[1]);
        esum = (2*EW+2)'(esq_reg[0]) + (2*EW+2)'(esq_reg[1]) + (2*EW+2)'(esq_reg[2]);
        if (cfg.half_length == '0)
        begin
            inside_next = fl5_reg.sphere_in;
        end
        else
        begin
            inside_next = fl5_reg.radial_ok
                       && (rsum <= (2*RSW+1)'(rs2))
                       && (fl5_reg.body_in || (esum <= (2*EW+2)'(rs2)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            inside_reg <= inside_next;
        end
    end

    assign inside_res = inside_reg;

endmodule

@@ design/pic_chk.sv @@
module pic_chk (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic inside_res
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("input item dropped while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output item dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(inside_res))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid after reset");

    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output stage");

endmodule

bind point_in_capsule_test_top pic_chk u_pic_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .inside_res (inside_res)
);

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import pic_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic [1:0]            setup;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic                  known;
        logic                  res;
    } probe_t;

    localparam logic [1:0] SETUP_RESET   = 2'd0;
    localparam logic [1:0] SETUP_CAPSULE = 2'd1;
    localparam logic [1:0] SETUP_EXTREME = 2'd2;
    localparam int NPROBE        = 24;
    localparam int HOLD_CYCLES   = 80;
    localparam int ITEMS_PER_PHASE = 100;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [IDX_W-1:0]             cfg_index = '0;
    logic [CFG_W-1:0]             cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [COORD_BITS-1:0] point_x = '0;
    logic signed [COORD_BITS-1:0] point_y = '0;
    logic signed [COORD_BITS-1:0] point_z = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         inside_res;

    // capsule as last written
    logic signed [COORD_BITS-1:0] cen_x = '0;
    logic signed [COORD_BITS-1:0] cen_y = '0;
    logic signed [COORD_BITS-1:0] cen_z = '0;
    logic [AXW-1:0]               ax_side = AXIS_ONE;
    logic [AXW-1:0]               ax_long = AXIS_ONE << AXIS_BITS;
    logic [AXW-1:0]               ax_depth = AXIS_ONE << (2 * AXIS_BITS);
    logic [LENW-1:0]              rad_q = RADIUS_RESET;
    logic [LENW-1:0]              hlen_q = '0;

    logic inside_due [$];
    logic want;
    int   mismatches = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    logic hold_start = 1'b0;
    int   hold_left = 0;

    probe_t probes [NPROBE] = '{
        // unit sphere after reset
        '{SETUP_RESET, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1},
        '{SETUP_RESET, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1},
        '{SETUP_RESET, 32'h0001_0001, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0},
        '{SETUP_RESET, 32'h0000_0000, 32'hFFFF_0000, 32'h0000_0000, 1'b1, 1'b1},
        '{SETUP_RESET, 32'h0000_93CD, 32'h0000_93CD, 32'h0000_93CD, 1'b1, 1'b1},
        '{SETUP_RESET, 32'h0000_93CE, 32'h0000_93CE, 32'h0000_93CE, 1'b1, 1'b0},
        '{SETUP_RESET, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0},
        '{SETUP_RESET, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0},
        // radius 1, half length 2, identity axes
        '{SETUP_CAPSULE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1},
        '{SETUP_CAPSULE, 32'h0000_0000, 32'h0002_0000, 32'h0000_0000, 1'b1, 1'b1},
        '{SETUP_CAPSULE, 32'h0000_0000, 32'hFFFE_0000, 32'h0000_0000, 1'b1, 1'b1},
        '{SETUP_CAPSULE, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000, 1'b1, 1'b1},
        '{SETUP_CAPSULE, 32'h0000_0000, 32'h0003_0001, 32'h0000_0000, 1'b1, 1'b0},
        '{SETUP_CAPSULE, 32'h0000_0000, 32'hFFFD_0000, 32'h0000_0000, 1'b1, 1'b1},
        '{SETUP_CAPSULE, 32'h0000_0000, 32'hFFFC_FFFF, 32'h0000_0000, 1'b1, 1'b0},
        '{SETUP_CAPSULE, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1},
        '{SETUP_CAPSULE, 32'h0001_0001, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0},
        '{SETUP_CAPSULE, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000, 1'b1, 1'b1},
        '{SETUP_CAPSULE, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 1'b1, 1'b1},
        '{SETUP_CAPSULE, 32'h0001_0000, 32'h0002_0001, 32'h0000_0000, 1'b1, 1'b0},
        '{SETUP_CAPSULE, 32'h0000_B504, 32'h0000_0000, 32'h0000_B504, 1'b1, 1'b1},
        '{SETUP_CAPSULE, 32'h0000_B505, 32'h0000_0000, 32'h0000_B505, 1'b1, 1'b0},
        // extreme capsule, predicted
        '{SETUP_EXTREME, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0},
        '{SETUP_EXTREME, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0}
    };

    point_in_capsule_test_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .inside_res (inside_res)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic wide_t axis_part(input logic [AXW-1:0] v, input int k);
        logic signed [AXIS_BITS-1:0] c;
        wide_t w;
        c = v[k*AXIS_BITS +: AXIS_BITS];
        w = c;
        return w;
    endfunction

    function automatic wide_t project(input wide_t dx, input wide_t dy, input wide_t dz,
                                      input logic [AXW-1:0] v);
        return dx * axis_part(v, 0) + dy * axis_part(v, 1) + dz * axis_part(v, 2);
    endfunction

    function automatic wide_t mag(input wide_t a);
        return (a < 0) ? -a : a;
    endfunction

    function automatic logic predict_inside(input logic signed [COORD_BITS-1:0] qx,
                                            input logic signed [COORD_BITS-1:0] qy,
                                            input logic signed [COORD_BITS-1:0] qz);
        wide_t dx, dy, dz, cx, cy, cz, r, h, scale, rs, rs2;
        wide_t sx, sz, sy, ex, ey, ez;
        dx = qx;
        dy = qy;
        dz = qz;
        cx = cen_x;
        cy = cen_y;
        cz = cen_z;
        dx = dx - cx;
        dy = dy - cy;
        dz = dz - cz;
        r = rad_q;
        h = hlen_q;
        scale = 1;
        scale = scale <<< AXIS_FRAC;
        rs = r * scale;
        rs2 = rs * rs;
        if (hlen_q == '0)
            return (dx * dx + dy * dy + dz * dz) <= r * r;
        sx = mag(project(dx, dy, dz, ax_side));
        sz = mag(project(dx, dy, dz, ax_depth));
        if (sx > rs || sz > rs)
            return 1'b0;
        if (sx * sx + sz * sz > rs2)
            return 1'b0;
        sy = project(dx, dy, dz, ax_long);
        if (mag(sy) < h * scale)
            return 1'b1;
        // nearer end sphere, surface included
        if (sy >= 0)
        begin
            ex = dx * scale - axis_part(ax_long, 0) * h;
            ey = dy * scale - axis_part(ax_long, 1) * h;
            ez = dz * scale - axis_part(ax_long, 2) * h;
        end
        else
        begin
            ex = dx * scale + axis_part(ax_long, 0) * h;
            ey = dy * scale + axis_part(ax_long, 1) * h;
            ez = dz * scale + axis_part(ax_long, 2) * h;
        end
        return (ex * ex + ey * ey + ez * ez) <= rs2;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] near_coord(
        input logic signed [COORD_BITS-1:0] c
    );
        longint unsigned span, pick;
        span = 64'(rad_q) + 64'(hlen_q);
        span = span + span / 4 + 4;
        pick = {$urandom, $urandom} % (2 * span + 1);
        return c + COORD_BITS'(pick - span);
    endfunction

    function automatic logic [AXW-1:0] unit_axis(input int pos, input bit neg);
        logic [AXW-1:0] v;
        v = '0;
        v[pos*AXIS_BITS +: AXIS_BITS] = neg ? AXIS_BITS'(-(1 << AXIS_FRAC))
                                            : AXIS_BITS'(1 << AXIS_FRAC);
        return v;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_CENTER_X:    cen_x = data[COORD_BITS-1:0];
            REG_CENTER_Y:    cen_y = data[COORD_BITS-1:0];
            REG_CENTER_Z:    cen_z = data[COORD_BITS-1:0];
            REG_AXIS_SIDE:   ax_side = data[AXW-1:0];
            REG_AXIS_LONG:   ax_long = data[AXW-1:0];
            REG_AXIS_DEPTH:  ax_depth = data[AXW-1:0];
            REG_RADIUS:      rad_q = data[LENW-1:0];
            REG_HALF_LENGTH: hlen_q = data[LENW-1:0];
            default: ;
        endcase
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (inside_due.size() != 0)
            @(posedge clk);
        repeat (NSTAGE + 2)
            @(posedge clk);
    endtask

    task automatic send_point(input logic signed [COORD_BITS-1:0] qx,
                              input logic signed [COORD_BITS-1:0] qy,
                              input logic signed [COORD_BITS-1:0] qz,
                              input logic known, input logic res);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        point_x <= qx;
        point_y <= qy;
        point_z <= qz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        inside_due.push_back(known ? res : predict_inside(qx, qy, qz));
    endtask

    task automatic random_capsule(input bit extreme);
        logic [CFG_W-1:0] dat;
        logic [31:0]      c;
        logic [AXW-1:0]   a_side, a_long, a_depth;
        int               p0, p1, pick;
        for (int k = 0; k < 3; k++)
        begin
            c = $urandom;
            if ($urandom_range(1))
                c = $signed(c) >>> 8;
            if (extreme)
                c = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            dat = CFG_W'({$urandom, $urandom});
            dat[COORD_BITS-1:0] = c;
            write_reg(REG_CENTER_X + IDX_W'(k), dat);
        end
        pick = $urandom_range(3);
        case (pick)
            0:
            begin
                p0 = $urandom_range(2);
                p1 = (p0 + 1 + $urandom_range(1)) % 3;
                a_side = unit_axis(p0, 1'($urandom_range(1)));
                a_long = unit_axis(p1, 1'($urandom_range(1)));
                a_depth = unit_axis(3 - p0 - p1, 1'($urandom_range(1)));
            end
            1:
            begin
                // rotated 45 degrees about z
                a_side = {16'h0000, 16'd11585, 16'd11585};
                a_long = {16'h0000, 16'd11585, 16'hD2BF};
                a_depth = unit_axis(2, 1'b0);
            end
            2:
            begin
                a_side = AXW'({$urandom, $urandom});
                a_long = AXW'({$urandom, $urandom});
                a_depth = AXW'({$urandom, $urandom});
            end
            default:
            begin
                a_side = unit_axis(0, 1'b0);
                a_long = unit_axis(1, 1'b0);
                a_depth = unit_axis(2, 1'b0);
            end
        endcase
        if (extreme)
        begin
            a_side = {3{16'h8000}};
            a_long = {3{16'h7FFF}};
        end
        write_reg(REG_AXIS_SIDE, {$urandom, 16'(a_side >> 32)} << 32 | CFG_W'(a_side));
        write_reg(REG_AXIS_LONG, CFG_W'(a_long));
        write_reg(REG_AXIS_DEPTH, CFG_W'(a_depth));
        dat = CFG_W'({$urandom, $urandom});
        pick = $urandom_range(4);
        if (extreme)
            dat[LENW-1:0] = '1;
        else if (pick == 0)
            dat[LENW-1:0] = '0;
        else if (pick == 1)
            dat[LENW-1:0] = LENW'($urandom_range(32'h0004_0000, 1));
        else
            dat[LENW-1:0] = LENW'($urandom_range(32'h0080_0000, 32'h0000_1000));
        write_reg(REG_RADIUS, dat);
        dat = CFG_W'({$urandom, $urandom});
        pick = $urandom_range(2);
        if (extreme)
            dat[LENW-1:0] = '1;
        else if (pick == 0)
            dat[LENW-1:0] = '0;
        else
            dat[LENW-1:0] = LENW'($urandom_range(32'h0100_0000, 1));
        write_reg(REG_HALF_LENGTH, dat);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (inside_due.size() == 0)
                    report("result with nothing pending");
                else
                begin
                    want = inside_due.pop_front();
                    if (inside_res !== want)
                        report($sformatf("inside_res %b, predicted %b", inside_res, want));
                end
            end
            if (hold_start)
            begin
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        logic [1:0]                   cur;
        int                           kind;
        logic signed [COORD_BITS-1:0] qx, qy, qz;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur = SETUP_RESET;
        for (int i = 0; i < NPROBE; i++)
        begin
            if (probes[i].setup != cur)
            begin
                drain_pipe();
                cur = probes[i].setup;
                if (cur == SETUP_CAPSULE)
                begin
                    write_reg(REG_RADIUS, CFG_W'(32'h0001_0000));
                    write_reg(REG_HALF_LENGTH, CFG_W'(32'h0002_0000));
                end
                else
                begin
                    // upper data bits set to check masking
                    write_reg(REG_CENTER_X, 48'hFFFF_8000_0000);
                    write_reg(REG_CENTER_Y, 48'h0000_7FFF_FFFF);
                    write_reg(REG_CENTER_Z, 48'hABCD_0000_0000);
                    write_reg(REG_AXIS_SIDE, {3{16'h8000}});
                    write_reg(REG_AXIS_LONG, {3{16'h7FFF}});
                    write_reg(REG_AXIS_DEPTH, {16'h8000, 16'h7FFF, 16'h0000});
                    write_reg(REG_RADIUS, 48'hFFFF_FFFF_FFFF);
                    write_reg(REG_HALF_LENGTH, 48'hFFFF_FFFF_FFFF);
                end
                cfg_valid <= 1'b0;
            end
            send_point(probes[i].x, probes[i].y, probes[i].z,
                       probes[i].known, probes[i].res);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            drain_pipe();
            case (ph >> 1)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 78; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 78; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            random_capsule(ph == 7);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == 1 && n == 0)
                    hold_start <= 1'b1;
                if (ph == 1 && n == 2)
                    hold_start <= 1'b0;
                if (ph == 3 && n == 50)
                begin
                    in_valid <= 1'b0;
                    while (inside_due.size() != 0)
                        @(posedge clk);
                end
                kind = $urandom_range(9);
                if (kind < 2)
                begin
                    qx = $urandom;
                    qy = $urandom;
                    qz = $urandom;
                end
                else if (kind == 2)
                begin
                    qx = cen_x;
                    qy = cen_y;
                    qz = cen_z;
                end
                else
                begin
                    qx = near_coord(cen_x);
                    qy = near_coord(cen_y);
                    qz = near_coord(cen_z);
                end
                send_point(qx, qy, qz, 1'b0, 1'b0);
            end
        end

        in_valid <= 1'b0;
        stall_pct = 0;
        while (inside_due.size() != 0)
            @(posedge clk);
        repeat (NSTAGE + 4)
            @(posedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
